[rtl/backslash_newline_splicer_top_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the backslash-newline splicer
// Shared concurrent-check shorthands, clocked on clk, quiet during reset.
// ----------------------------------------------------------------------------
`ifndef BACKSLASH_NEWLINE_SPLICER_TOP_MACROS_SVH
`define BACKSLASH_NEWLINE_SPLICER_TOP_MACROS_SVH

// Same-cycle implication.
`define BNS_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("splicer check failed");

// Next-cycle implication.
`define BNS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("splicer check failed");

`endif

[rtl/bns_pkg.sv]
// ----------------------------------------------------------------------------
// bns_pkg
// Constants and job header type shared by the splicer modules.
// ----------------------------------------------------------------------------
`default_nettype none

package bns_pkg;

  localparam logic [7:0] CH_BACKSLASH = 8'h5C;
  localparam logic [7:0] CH_NEWLINE   = 8'h0A;

  localparam logic KIND_BYTE = 1'b0;
  localparam logic KIND_END  = 1'b1;

  localparam int MAX_DEFERRED_NEWLINES_DEF = 63;

  // Everything about one pending output run except the newline replay count.
  typedef struct packed {
    logic       pre_bs;   // emit a backslash ahead of the final byte
    logic [7:0] data;     // final byte of the run
    logic       fin_end;  // final byte closes the stream
  } job_hdr_t;

endpackage

`default_nettype wire

[rtl/bns_emit.sv]
// ----------------------------------------------------------------------------
// bns_emit
// Two-slot job queue and result sequencer: plays one run per job.
// ----------------------------------------------------------------------------
`default_nettype none

`include "backslash_newline_splicer_top_macros.svh"

module bns_emit #(
  parameter int MAX_DEFERRED_NEWLINES = bns_pkg::MAX_DEFERRED_NEWLINES_DEF
) (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  new_v,
  input  wire bns_pkg::job_hdr_t new_hdr,
  input  wire  [$clog2(MAX_DEFERRED_NEWLINES+1)-1:0] new_nl,
  output logic                 full,
  output logic                 out_valid,
  input  wire                  out_stall,
  output logic [7:0]           out_byte,
  output logic                 out_run_last,
  output logic                 out_stream_end
);

  localparam int CntW = $clog2(MAX_DEFERRED_NEWLINES + 1);

  logic              head_v_r, head_v_nxt;
  bns_pkg::job_hdr_t head_hdr_r, head_hdr_nxt;
  logic [CntW-1:0]   head_nl_r, head_nl_nxt;
  logic              tail_v_r, tail_v_nxt;
  bns_pkg::job_hdr_t tail_hdr_r, tail_hdr_nxt;
  logic [CntW-1:0]   tail_nl_r, tail_nl_nxt;

  logic out_take;
  logic last_sel;
  logic head_done;
  logic head_free;

  assign full     = tail_v_r;
  assign out_take = head_v_r & ~out_stall;
  assign last_sel = ~head_hdr_r.pre_bs & (head_nl_r == '0);
  assign head_done = out_take & last_sel;
  assign head_free = ~head_v_r | head_done;

  // Result selection: backslash prefix, then replayed newlines, then the byte.
  always_comb begin
    out_valid      = head_v_r;
    out_byte       = head_hdr_r.data;
    out_run_last   = 1'b1;
    out_stream_end = head_hdr_r.fin_end;
    if (head_hdr_r.pre_bs) begin
      out_byte       = bns_pkg::CH_BACKSLASH;
      out_run_last   = 1'b0;
      out_stream_end = 1'b0;
    end else if (head_nl_r != '0) begin
      out_byte       = bns_pkg::CH_NEWLINE;
      out_run_last   = 1'b0;
      out_stream_end = 1'b0;
    end
  end

  always_comb begin
    head_v_nxt   = head_v_r;
    head_hdr_nxt = head_hdr_r;
    head_nl_nxt  = head_nl_r;
    tail_v_nxt   = tail_v_r;
    tail_hdr_nxt = tail_hdr_r;
    tail_nl_nxt  = tail_nl_r;
    if (head_free) begin
      if (tail_v_r) begin
        head_v_nxt   = 1'b1;
        head_hdr_nxt = tail_hdr_r;
        head_nl_nxt  = tail_nl_r;
        tail_v_nxt   = 1'b0;
      end else begin
        head_v_nxt   = new_v;
        head_hdr_nxt = new_hdr;
        head_nl_nxt  = new_nl;
      end
    end else begin
      if (out_take) begin
        if (head_hdr_r.pre_bs) begin
          head_hdr_nxt.pre_bs = 1'b0;
        end else begin
          head_nl_nxt = head_nl_r - 1'b1;
        end
      end
      if (new_v) begin
        tail_v_nxt   = 1'b1;
        tail_hdr_nxt = new_hdr;
        tail_nl_nxt  = new_nl;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_v_r   <= 1'b0;
      tail_v_r   <= 1'b0;
      head_hdr_r <= '0;
      head_nl_r  <= '0;
    end else begin
      head_v_r   <= head_v_nxt;
      tail_v_r   <= tail_v_nxt;
      head_hdr_r <= head_hdr_nxt;
      head_nl_r  <= head_nl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    tail_hdr_r <= tail_hdr_nxt;
    tail_nl_r  <= tail_nl_nxt;
  end

  `BNS_ASSERT_NOW(a_tail_needs_head, tail_v_r, head_v_r)
  `BNS_ASSERT_NOW(a_no_bs_with_replay, head_v_r && head_hdr_r.pre_bs, head_nl_r == '0)
  `BNS_ASSERT_NEXT(a_head_holds, head_v_r && out_stall, head_v_r)
  `BNS_ASSERT_NEXT(a_head_drains, head_done && !tail_v_r && !new_v, !head_v_r)
  `BNS_ASSERT_NOW(a_no_take_when_full, tail_v_r, !new_v)

endmodule

`default_nettype wire

[rtl/backslash_newline_splicer_top.sv]
// Results are registered: they come from the job queue's head slot, not straight from the input.
// Throughput: one item per cycle while the job queue is not full; an item yields 0, 1, 2 or
// 1 + replayed-newline results, one result per cycle while out_stall is low.
// A two-slot job queue lets one more item in while a run is still draining.
// Reset (synchronous, rst_n low): clears escape and replay count, empties the job queue.
// ----------------------------------------------------------------------------
// backslash_newline_splicer_top
// Deletes backslash-newline pairs from a byte stream and replays the deleted
// newlines ahead of the next plain newline, keeping line numbers aligned.
// ----------------------------------------------------------------------------
`default_nettype none

module backslash_newline_splicer_top #(
  parameter int MAX_DEFERRED_NEWLINES = bns_pkg::MAX_DEFERRED_NEWLINES_DEF
) (
  input  wire        clk,
  input  wire        rst_n,
  input  wire        in_valid,
  output logic       in_stall,
  input  wire        in_kind,
  input  wire  [7:0] in_byte,
  output logic       out_valid,
  input  wire        out_stall,
  output logic [7:0] out_byte,
  output logic       out_run_last,
  output logic       out_stream_end
);

  localparam int CntW = $clog2(MAX_DEFERRED_NEWLINES + 1);
  localparam logic [CntW-1:0] CntMax = CntW'(MAX_DEFERRED_NEWLINES);

  // Splice state: an unconsumed backslash and the count of deleted newlines.
  logic            esc_r, esc_nxt;
  logic [CntW-1:0] def_r, def_nxt;

  logic              in_take;
  logic              q_full;
  logic              job_v;
  bns_pkg::job_hdr_t job_hdr;
  logic [CntW-1:0]   job_nl;
  logic              is_bs;
  logic              is_nl;

  // Accept whenever the queue's spare slot is free.
  assign in_stall = q_full;
  assign in_take  = in_valid & ~q_full;
  assign is_bs    = (in_byte == bns_pkg::CH_BACKSLASH);
  assign is_nl    = (in_byte == bns_pkg::CH_NEWLINE);

  // Decode one item into a job (or none) and the next splice state.
  always_comb begin
    esc_nxt         = esc_r;
    def_nxt         = def_r;
    job_v           = 1'b0;
    job_hdr.pre_bs  = 1'b0;
    job_hdr.data    = in_byte;
    job_hdr.fin_end = 1'b0;
    job_nl          = '0;
    if (in_kind == bns_pkg::KIND_END) begin
      // Flush a pending backslash, close with a newline, drop the replay count.
      job_v           = 1'b1;
      job_hdr.pre_bs  = esc_r;
      job_hdr.data    = bns_pkg::CH_NEWLINE;
      job_hdr.fin_end = 1'b1;
      esc_nxt         = 1'b0;
      def_nxt         = '0;
    end else if (esc_r) begin
      esc_nxt = 1'b0;
      if (is_nl) begin
        // Escaped newline: drop it, count it (saturating).
        if (def_r < CntMax) begin
          def_nxt = def_r + 1'b1;
        end
      end else begin
        // Backslash pairs with any other byte: pass both through.
        job_v          = 1'b1;
        job_hdr.pre_bs = 1'b1;
      end
    end else if (is_bs) begin
      // Hold the backslash until the next byte decides.
      esc_nxt = 1'b1;
    end else begin
      job_v = 1'b1;
      if (is_nl) begin
        // Plain newline: replay all deleted newlines ahead of it.
        job_nl  = def_r;
        def_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      esc_r <= 1'b0;
      def_r <= '0;
    end else if (in_take) begin
      esc_r <= esc_nxt;
      def_r <= def_nxt;
    end
  end

  bns_emit #(
    .MAX_DEFERRED_NEWLINES(MAX_DEFERRED_NEWLINES)
  ) u_emit (
    .clk            (clk),
    .rst_n          (rst_n),
    .new_v          (in_take & job_v),
    .new_hdr        (job_hdr),
    .new_nl         (job_nl),
    .full           (q_full),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_byte       (out_byte),
    .out_run_last   (out_run_last),
    .out_stream_end (out_stream_end)
  );

endmodule

`default_nettype wire

[verif/backslash_newline_splicer_top_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// backslash_newline_splicer_top_tb
// Self-checking bench for the line splicer. Feeds byte and end-of-stream
// items through the valid/stall input, predicts every emitted byte in a local
// model of the escape and replay state, and checks each accepted result in
// order. Both sides idle and stall at random; one phase fills the block.
// ----------------------------------------------------------------------------

module backslash_newline_splicer_top_tb;

  localparam int REPLAY_LIMIT = bns_pkg::MAX_DEFERRED_NEWLINES_DEF;
  localparam int RANDOM_ITEMS = 120;

  // One emitted byte with its flags, in the order the block must produce them.
  typedef struct packed {
    logic [7:0] ch;
    logic       run_last;
    logic       stream_end;
  } spliced_char_t;

  logic       clk;
  logic       rst_n     = 1'b0;
  logic       in_valid  = 1'b0;
  logic       in_kind   = bns_pkg::KIND_BYTE;
  logic [7:0] in_byte   = 8'h00;
  logic       out_stall = 1'b0;
  logic       in_stall;
  logic       out_valid;
  logic [7:0] out_byte;
  logic       out_run_last;
  logic       out_stream_end;

  // Local copy of the splicer state.
  logic       esc_pending = 1'b0;
  logic [5:0] deferred_nl = '0;

  spliced_char_t pending_chars[$];

  // Stimulus controls and run statistics.
  bit gaps_on  = 1'b1;
  bit stall_on = 1'b1;
  int hold_req = 0;
  int stall_left = 0;
  int fail_count = 0;
  int items_sent = 0;
  int ends_sent = 0;
  int results_seen = 0;
  int longest_run = 0;
  int in_stall_cycles = 0;

  backslash_newline_splicer_top DUT (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_kind       (in_kind),
    .in_byte       (in_byte),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_byte      (out_byte),
    .out_run_last  (out_run_last),
    .out_stream_end(out_stream_end)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop in case the block wedges or drops results.
  initial begin
    #(50_000_000);
    $display("backslash_newline_splicer_top regression: fail");
    $finish;
  end

  // Count a failure; print details only for the first few.
  function automatic void log_failure(input string what);
    fail_count++;
    if (fail_count <= 10) begin
      $display("[%0t] MISMATCH: %s", $time, what);
    end
  endfunction

  // Idle length for either side: mostly none, some short, a few long.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) begin
      return 0;
    end else if (r < 92) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 30);
  endfunction

  function automatic void queue_char(input logic [7:0] ch, input logic last,
                                     input logic fin);
    spliced_char_t c;
    c.ch         = ch;
    c.run_last   = last;
    c.stream_end = fin;
    pending_chars.insert(pending_chars.size(), c);
  endfunction

  // Predict the bytes one accepted item produces and advance the local state.
  function automatic void splice_predict(input logic kind, input logic [7:0] ch);
    int produced;
    produced = pending_chars.size();
    if (kind == bns_pkg::KIND_END) begin
      // Flush a dangling backslash, drop any deferred newlines, close stream.
      if (esc_pending) begin
        queue_char(bns_pkg::CH_BACKSLASH, 1'b0, 1'b0);
      end
      queue_char(bns_pkg::CH_NEWLINE, 1'b1, 1'b1);
      esc_pending = 1'b0;
      deferred_nl = '0;
    end else if (esc_pending) begin
      esc_pending = 1'b0;
      if (ch == bns_pkg::CH_NEWLINE) begin
        // Spliced line: swallow the pair, remember one newline (saturating).
        if (int'(deferred_nl) < REPLAY_LIMIT) begin
          deferred_nl = deferred_nl + 6'd1;
        end
      end else begin
        queue_char(bns_pkg::CH_BACKSLASH, 1'b0, 1'b0);
        queue_char(ch, 1'b1, 1'b0);
      end
    end else if (ch == bns_pkg::CH_BACKSLASH) begin
      esc_pending = 1'b1;
    end else begin
      if (ch == bns_pkg::CH_NEWLINE) begin
        // Replay the swallowed newlines ahead of this one.
        for (int i = 0; i < int'(deferred_nl); i++) begin
          queue_char(bns_pkg::CH_NEWLINE, 1'b0, 1'b0);
        end
        deferred_nl = '0;
      end
      queue_char(ch, 1'b1, 1'b0);
    end
    produced = pending_chars.size() - produced;
    if (produced > longest_run) begin
      longest_run = produced;
    end
  endfunction

  // Offer one item, hold it until accepted, predict, then maybe idle.
  task automatic send_item(input logic kind, input logic [7:0] ch);
    int gap;
    in_valid <= 1'b1;
    in_kind  <= kind;
    in_byte  <= ch;
    @(posedge clk);
    while (in_stall) begin
      in_stall_cycles++;
      @(posedge clk);
    end
    splice_predict(kind, ch);
    items_sent++;
    if (kind == bns_pkg::KIND_END) begin
      ends_sent++;
    end
    gap = gaps_on ? pick_gap() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Stop offering and wait until every predicted byte has come out.
  task automatic wait_drain();
    in_valid <= 1'b0;
    while (pending_chars.size() != 0) begin
      @(posedge clk);
    end
    repeat (4) @(posedge clk);
  endtask

  // One source line of printable text with continuations and escapes mixed in.
  task automatic send_line(input int max_len);
    int len;
    int r;
    logic [7:0] ch;
    len = $urandom_range(0, max_len);
    for (int i = 0; i < len; i++) begin
      r = $urandom_range(0, 99);
      if (r < 12) begin
        send_item(bns_pkg::KIND_BYTE, bns_pkg::CH_BACKSLASH);
        send_item(bns_pkg::KIND_BYTE, bns_pkg::CH_NEWLINE);
      end else if (r < 20) begin
        send_item(bns_pkg::KIND_BYTE, bns_pkg::CH_BACKSLASH);
        send_item(bns_pkg::KIND_BYTE, 8'($urandom));
      end else begin
        ch = 8'($urandom_range(8'h20, 8'h7E));
        if (ch == bns_pkg::CH_BACKSLASH) begin
          ch = ch ^ 8'h01;
        end
        send_item(bns_pkg::KIND_BYTE, ch);
      end
    end
    send_item(bns_pkg::KIND_BYTE, bns_pkg::CH_NEWLINE);
  endtask

  // Directed corner cases: byte extremes, every escape combination and the
  // end-of-stream variants.
  task automatic test_directed_cases();
    send_item(bns_pkg::KIND_BYTE, 8'h00);
    send_item(bns_pkg::KIND_BYTE, 8'hFF);
    send_item(bns_pkg::KIND_BYTE, bns_pkg::CH_NEWLINE);
    // Backslash followed by an ordinary byte passes both through.
    send_item(bns_pkg::KIND_BYTE, bns_pkg::CH_BACKSLASH);
    send_item(bns_pkg::KIND_BYTE, 8'h6E);
    send_item(bns_pkg::KIND_BYTE, bns_pkg::CH_BACKSLASH);
    send_item(bns_pkg::KIND_BYTE, 8'hFF);
    // Double backslash: both emitted, nothing left pending.
    send_item(bns_pkg::KIND_BYTE, bns_pkg::CH_BACKSLASH);
    send_item(bns_pkg::KIND_BYTE, bns_pkg::CH_BACKSLASH);
    // Two spliced lines, then a plain newline replays them.
    send_item(bns_pkg::KIND_BYTE, bns_pkg::CH_BACKSLASH);
    send_item(bns_pkg::KIND_BYTE, bns_pkg::CH_NEWLINE);
    send_item(bns_pkg::KIND_BYTE, bns_pkg::CH_BACKSLASH);
    send_item(bns_pkg::KIND_BYTE, bns_pkg::CH_NEWLINE);
    send_item(bns_pkg::KIND_BYTE, bns_pkg::CH_NEWLINE);
    // End of stream with a backslash still pending.
    send_item(bns_pkg::KIND_BYTE, bns_pkg::CH_BACKSLASH);
    send_item(bns_pkg::KIND_END, 8'h00);
    // End of stream drops deferred newlines.
    send_item(bns_pkg::KIND_BYTE, bns_pkg::CH_BACKSLASH);
    send_item(bns_pkg::KIND_BYTE, bns_pkg::CH_NEWLINE);
    send_item(bns_pkg::KIND_END, 8'hFF);
    // Plain end of stream, byte field ignored.
    send_item(bns_pkg::KIND_END, bns_pkg::CH_BACKSLASH);
    // Odd run of backslashes leaves one pending, which escapes the newline.
    send_item(bns_pkg::KIND_BYTE, bns_pkg::CH_BACKSLASH);
    send_item(bns_pkg::KIND_BYTE, bns_pkg::CH_BACKSLASH);
    send_item(bns_pkg::KIND_BYTE, bns_pkg::CH_BACKSLASH);
    send_item(bns_pkg::KIND_BYTE, bns_pkg::CH_NEWLINE);
    send_item(bns_pkg::KIND_BYTE, 8'h78);
    send_item(bns_pkg::KIND_BYTE, bns_pkg::CH_NEWLINE);
    wait_drain();
  endtask

  // Splice more lines than the counter holds, then replay the capped run.
  task automatic test_replay_saturation();
    repeat (REPLAY_LIMIT + 3) begin
      send_item(bns_pkg::KIND_BYTE, bns_pkg::CH_BACKSLASH);
      send_item(bns_pkg::KIND_BYTE, bns_pkg::CH_NEWLINE);
    end
    send_item(bns_pkg::KIND_BYTE, bns_pkg::CH_NEWLINE);
    // Counter must be back at zero: a short replay follows.
    repeat (2) begin
      send_item(bns_pkg::KIND_BYTE, bns_pkg::CH_BACKSLASH);
      send_item(bns_pkg::KIND_BYTE, bns_pkg::CH_NEWLINE);
    end
    send_item(bns_pkg::KIND_BYTE, bns_pkg::CH_NEWLINE);
    wait_drain();
  endtask

  // Hold the output off for a long stretch while items keep coming, so the
  // job queue fills and the input stalls; then pause until all is drained.
  task automatic test_backpressure();
    gaps_on = 1'b0;
    hold_req <= 150;
    repeat (2) begin
      send_item(bns_pkg::KIND_BYTE, bns_pkg::CH_BACKSLASH);
      send_item(bns_pkg::KIND_BYTE, bns_pkg::CH_NEWLINE);
    end
    repeat (4) send_line(6);
    wait_drain();
    gaps_on = 1'b1;
  endtask

  // Mostly well-formed lines with random content, some noise bursts heavy in
  // backslashes and newlines, and the odd end of stream.
  task automatic test_random_stream();
    int goal;
    int r;
    goal = items_sent + RANDOM_ITEMS;
    while (items_sent < goal) begin
      gaps_on  = ($urandom_range(0, 3) != 0);
      stall_on = ($urandom_range(0, 3) != 0);
      r = $urandom_range(0, 9);
      if (r < 7) begin
        send_line(12);
      end else if (r < 9) begin
        repeat ($urandom_range(1, 6)) begin
          r = $urandom_range(0, 99);
          if (r < 30) begin
            send_item(bns_pkg::KIND_BYTE, bns_pkg::CH_BACKSLASH);
          end else if (r < 55) begin
            send_item(bns_pkg::KIND_BYTE, bns_pkg::CH_NEWLINE);
          end else begin
            send_item(bns_pkg::KIND_BYTE, 8'($urandom));
          end
        end
      end else begin
        send_item(bns_pkg::KIND_END, 8'($urandom));
      end
    end
    gaps_on  = 1'b1;
    stall_on = 1'b1;
    wait_drain();
  endtask

  // Receiver stall: a requested hold-off wins, then random stall bursts.
  always @(posedge clk) begin
    if (hold_req > 0) begin
      out_stall <= 1'b1;
      hold_req  <= hold_req - 1;
    end else if (stall_left > 0) begin
      out_stall  <= 1'b1;
      stall_left <= stall_left - 1;
    end else if (stall_on && $urandom_range(0, 99) < 15) begin
      out_stall  <= 1'b1;
      stall_left <= pick_gap();
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Check every accepted result against the oldest prediction.
  always @(posedge clk) begin : check_results
    spliced_char_t want;
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (pending_chars.size() == 0) begin
        log_failure($sformatf("unexpected result byte=%02h last=%b end=%b",
                              out_byte, out_run_last, out_stream_end));
      end else begin
        want = pending_chars.pop_front();
        if (out_byte !== want.ch || out_run_last !== want.run_last ||
            out_stream_end !== want.stream_end) begin
          log_failure($sformatf(
            "expected byte=%02h last=%b end=%b, got byte=%02h last=%b end=%b",
            want.ch, want.run_last, want.stream_end,
            out_byte, out_run_last, out_stream_end));
        end
      end
    end
  end

  initial begin
    // Hold reset, then release it synchronously.
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_cases();
    test_replay_saturation();
    test_backpressure();
    test_random_stream();

    // Let any stray output show up before the verdict.
    repeat (10) @(posedge clk);

    $display("Sent %0d items (%0d end-of-stream), checked %0d output bytes.",
             items_sent, ends_sent, results_seen);
    $display("Longest replay run %0d bytes; input stalled %0d cycles; %0d mismatches.",
             longest_run, in_stall_cycles, fail_count);
    if (fail_count == 0) begin
      $display("backslash_newline_splicer_top regression: pass");
    end else begin
      $display("backslash_newline_splicer_top regression: fail");
    end
    $finish;
  end

endmodule

[files.f]
+incdir+rtl
rtl/bns_pkg.sv
rtl/bns_emit.sv
rtl/backslash_newline_splicer_top.sv
verif/backslash_newline_splicer_top_tb.sv
